// ----- rtl/sacs_pkg.sv -----
// ----------------------------------------------------------------------------
// Shift-add coefficient search package
// Shared types and constants for the search controller and datapath.
// ----------------------------------------------------------------------------
package sacs_pkg;

  localparam int unsigned ValW     = 64;
  localparam int unsigned ShW      = 6;
  localparam int unsigned AmtW     = 5;
  localparam int unsigned InDataW  = 6 * ValW;
  localparam int unsigned OutDataW = 16;

  typedef enum logic [1:0] {
    SG_PP = 2'd0,
    SG_NP = 2'd1,
    SG_PN = 2'd2
  } sign_e;

  typedef enum logic {
    ST_IDLE   = 1'b0,
    ST_SEARCH = 1'b1
  } state_e;

  typedef struct packed {
    logic load;
    logic step;
    logic finish;
  } cmd_t;

  typedef struct packed {
    logic hit;
    logic last;
  } status_t;

endpackage

// ----- rtl/sacs_dp.sv -----
// ----------------------------------------------------------------------------
// Shift-add coefficient search datapath
// Operand registers, candidate counters, one-candidate-per-cycle check and
// the result register.
// ----------------------------------------------------------------------------
module sacs_dp #(
  parameter int unsigned SHIFT_LIMIT = 20,
  parameter int unsigned LANES       = 2
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  sacs_pkg::cmd_t                    cmd_i,
  output sacs_pkg::status_t                 status_o,
  input  logic [sacs_pkg::InDataW-1:0]      in_data_i,
  input  logic                              in_two_lanes_i,
  output logic [sacs_pkg::OutDataW-1:0]     out_data_o
);

  localparam int unsigned MW = (SHIFT_LIMIT > 1) ? $clog2(SHIFT_LIMIT) : 1;
  localparam logic [MW-1:0] MLast = MW'(SHIFT_LIMIT - 1);
  localparam int unsigned VW = sacs_pkg::ValW;

  function automatic logic lane_match(
    input logic [VW-1:0]           l,
    input logic [VW-1:0]           r,
    input logic [VW-1:0]           t,
    input sacs_pkg::sign_e         sg,
    input logic [sacs_pkg::ShW-1:0] la,
    input logic [sacs_pkg::ShW-1:0] ra
  );
    logic [VW-1:0] lv;
    logic [VW-1:0] rv;
    logic [VW-1:0] sum;
    lv = l << la;
    rv = r << ra;
    case (sg)
      sacs_pkg::SG_NP: sum = rv - lv;
      sacs_pkg::SG_PN: sum = lv - rv;
      default:         sum = lv + rv;
    endcase
    return sum == t;
  endfunction

  logic [VW-1:0] left0_q, right0_q, target0_q;
  logic [MW-1:0] m_q, m_d, s_q, s_d;
  sacs_pkg::sign_e sg_q, sg_d;
  logic ord_q, ord_d;
  logic [MW-1:0] la, ra;
  logic hit0, hit1, hit;

  logic                      found_q;
  logic                      lneg_q, rneg_q;
  logic [sacs_pkg::AmtW-1:0] lamt_q, ramt_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      left0_q   <= in_data_i[0*VW +: VW];
      right0_q  <= in_data_i[2*VW +: VW];
      target0_q <= in_data_i[4*VW +: VW];
    end
  end

  assign la = ord_q ? s_q : m_q;
  assign ra = ord_q ? m_q : s_q;

  assign hit0 = lane_match(left0_q, right0_q, target0_q, sg_q,
                           sacs_pkg::ShW'(la), sacs_pkg::ShW'(ra));

  if (LANES > 1) begin : g_lane1
    logic [VW-1:0] left1_q, right1_q, target1_q;
    logic          two_q;

    always_ff @(posedge clk_i) begin
      if (cmd_i.load) begin
        left1_q   <= in_data_i[1*VW +: VW];
        right1_q  <= in_data_i[3*VW +: VW];
        target1_q <= in_data_i[5*VW +: VW];
        two_q     <= in_two_lanes_i;
      end
    end

    assign hit1 = !two_q || lane_match(left1_q, right1_q, target1_q, sg_q,
                                       sacs_pkg::ShW'(la), sacs_pkg::ShW'(ra));
  end else begin : g_no_lane1
    logic unused_in;
    assign unused_in = ^{in_data_i[VW +: VW], in_data_i[3*VW +: VW],
                         in_data_i[5*VW +: VW], in_two_lanes_i};
    assign hit1 = 1'b1 | unused_in;
  end

  assign hit = hit0 && hit1;

  assign status_o.hit  = hit;
  assign status_o.last = (m_q == MLast) && (s_q == m_q) &&
                         (sg_q == sacs_pkg::SG_PN) && ord_q;

  always_comb begin
    m_d   = m_q;
    s_d   = s_q;
    sg_d  = sg_q;
    ord_d = ord_q;
    if (cmd_i.load) begin
      m_d   = '0;
      s_d   = '0;
      sg_d  = sacs_pkg::SG_PP;
      ord_d = 1'b0;
    end else if (cmd_i.step) begin
      if (!ord_q) begin
        ord_d = 1'b1;
      end else begin
        ord_d = 1'b0;
        case (sg_q)
          sacs_pkg::SG_PP: sg_d = sacs_pkg::SG_NP;
          sacs_pkg::SG_NP: sg_d = sacs_pkg::SG_PN;
          default: begin
            sg_d = sacs_pkg::SG_PP;
            if (s_q == m_q) begin
              s_d = '0;
              m_d = m_q + MW'(1);
            end else begin
              s_d = s_q + MW'(1);
            end
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_q   <= '0;
      s_q   <= '0;
      sg_q  <= sacs_pkg::SG_PP;
      ord_q <= 1'b0;
    end else begin
      m_q   <= m_d;
      s_q   <= s_d;
      sg_q  <= sg_d;
      ord_q <= ord_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.finish) begin
      found_q <= hit;
      lneg_q  <= hit && (sg_q == sacs_pkg::SG_NP);
      rneg_q  <= hit && (sg_q == sacs_pkg::SG_PN);
      lamt_q  <= hit ? sacs_pkg::AmtW'(la) : '0;
      ramt_q  <= hit ? sacs_pkg::AmtW'(ra) : '0;
    end
  end

  assign out_data_o = sacs_pkg::OutDataW'({ramt_q, lamt_q, rneg_q, lneg_q, found_q});

endmodule

// ----- rtl/sacs_ctrl.sv -----
// ----------------------------------------------------------------------------
// Shift-add coefficient search controller
// Sequences request intake, the candidate sweep and the result handoff.
// ----------------------------------------------------------------------------
module sacs_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  input  sacs_pkg::status_t status_i,
  output sacs_pkg::cmd_t    cmd_o
);

  sacs_pkg::state_e state_q, state_d;
  logic out_valid_q, out_valid_d;
  logic out_free;
  logic done;

  assign out_free = !out_valid_q || out_ready_i;
  assign done     = status_i.hit || status_i.last;

  always_comb begin
    state_d = state_q;
    case (state_q)
      sacs_pkg::ST_IDLE: begin
        if (in_valid_i) state_d = sacs_pkg::ST_SEARCH;
      end
      sacs_pkg::ST_SEARCH: begin
        if (done && out_free) state_d = sacs_pkg::ST_IDLE;
      end
      default: state_d = sacs_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready_o    = 1'b0;
    cmd_o         = '0;
    case (state_q)
      sacs_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        cmd_o.load = in_valid_i;
      end
      sacs_pkg::ST_SEARCH: begin
        cmd_o.finish = done && out_free;
        cmd_o.step   = !done;
      end
      default: ;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.finish) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= sacs_pkg::ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

// ----- rtl/shift_add_coefficient_search_core.sv -----
// ----------------------------------------------------------------------------
// Shift-add coefficient search core
// Finds shifts and signs so that +/-(left << a) +/-(right << b) equals the
// target, modulo 2^64, in one or two lanes, and reports the first match.
// ----------------------------------------------------------------------------
// Usage:
// A request enters on the s_axis channel with the six operands in tdata and
// the two-lane flag in tuser. One result leaves on the m_axis channel.
// The search checks one candidate per clock cycle in a fixed order: larger
// shift upward, smaller shift up to it, three sign patterns, both orders.
// Without a match the sweep covers 3*SHIFT_LIMIT*(SHIFT_LIMIT+1) candidates,
// 1260 at the default limit, and the result reports found as zero.
// Each lane has its own shift-add-compare unit, all fed the same candidate.
// A new request is taken as soon as the previous search has handed its
// result to the output register, even while that result waits downstream.
// If the receiver stalls, a finished search holds until the register frees.
// Reset clears the controller and the output valid; no clearing pass is run.
// ----------------------------------------------------------------------------
module shift_add_coefficient_search_core #(
  parameter int unsigned SHIFT_LIMIT = 20,
  parameter int unsigned LANES       = 2
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  // left_a, left_b, right_a, right_b, target_a, target_b (64 bits each)
  input  logic [sacs_pkg::InDataW-1:0]  s_axis_tdata,
  // two_lanes
  input  logic                          s_axis_tuser,
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // found, left_negate, right_negate, left_amount[4:0], right_amount[4:0],
  // zero fill
  output logic [sacs_pkg::OutDataW-1:0] m_axis_tdata
);

  sacs_pkg::cmd_t    cmd;
  sacs_pkg::status_t status;

  sacs_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  sacs_dp #(
    .SHIFT_LIMIT (SHIFT_LIMIT),
    .LANES       (LANES)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .status_o       (status),
    .in_data_i      (s_axis_tdata),
    .in_two_lanes_i (s_axis_tuser),
    .out_data_o     (m_axis_tdata)
  );

`ifndef SYNTH
  a_busy_after_intake: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
    else $error("request taken while a search is running");

  a_not_found_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tdata[0]) |-> (m_axis_tdata[12:1] == '0))
    else $error("result fields set without a match");

  a_single_negate: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> !(m_axis_tdata[1] && m_axis_tdata[2]))
    else $error("both operands negated");

  a_result_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
    else $error("stalled result changed");
`endif

endmodule

// ----- tb/shift_add_coefficient_search_core_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Shift-add coefficient search core testbench
// Drives a directed table of requests and then random requests, most of them
// built to match at known shifts and signs, through both stream channels with
// random stalls. Results are checked against table or behavioral-model values.
// ----------------------------------------------------------------------------
module shift_add_coefficient_search_core_tb;

  localparam int unsigned ShiftLimit  = 20;
  localparam int unsigned Lanes       = 2;
  localparam int unsigned RandomCount = 450;
  localparam longint unsigned CycleLimit = 4_000_000;

  localparam logic [63:0] MaxVal  = 64'h7fff_ffff_ffff_ffff;
  localparam logic [63:0] MinVal  = 64'h8000_0000_0000_0000;
  localparam logic [63:0] AllOnes = 64'hffff_ffff_ffff_ffff;

  typedef struct packed {
    logic [63:0] left_a;
    logic [63:0] left_b;
    logic [63:0] right_a;
    logic [63:0] right_b;
    logic [63:0] target_a;
    logic [63:0] target_b;
    logic        two_lanes;
  } search_req_t;

  typedef struct packed {
    logic       found;
    logic       left_neg;
    logic       right_neg;
    logic [4:0] left_amt;
    logic [4:0] right_amt;
  } coeff_result_t;

  typedef struct packed {
    search_req_t   req;
    logic          known;
    coeff_result_t want;
  } table_row_t;

  logic                          clk_i;
  logic                          rst_ni;
  logic                          s_axis_tvalid;
  logic                          s_axis_tready;
  logic [sacs_pkg::InDataW-1:0]  s_axis_tdata;
  logic                          s_axis_tuser;
  logic                          m_axis_tvalid;
  logic                          m_axis_tready;
  logic [sacs_pkg::OutDataW-1:0] m_axis_tdata;

  coeff_result_t   coeff_expected_q[$];
  int unsigned     error_count;
  int unsigned     sent_count;
  int unsigned     hit_count;
  int unsigned     miss_count;
  int unsigned     dual_count;
  int unsigned     result_count;
  longint unsigned cycle_count;
  bit              steady_mode;
  int unsigned     stall_left;

  shift_add_coefficient_search_core #(
    .SHIFT_LIMIT(ShiftLimit),
    .LANES      (Lanes)
  ) dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  function automatic logic [63:0] lane_sum(input logic [63:0] l, input logic [63:0] r,
                                           input logic ln, input int unsigned la,
                                           input logic rn, input int unsigned ra);
    logic [63:0] lv;
    logic [63:0] rv;
    lv = l << la;
    rv = r << ra;
    return (ln ? -lv : lv) + (rn ? -rv : rv);
  endfunction

  function automatic coeff_result_t search_coeffs(input search_req_t r);
    coeff_result_t   res;
    sacs_pkg::sign_e sg;
    int unsigned     la;
    int unsigned     ra;
    logic            ln;
    logic            rn;
    logic            hit;
    logic            both;
    res  = '0;
    both = (Lanes >= 2) && r.two_lanes;
    for (int unsigned m = 0; m < ShiftLimit && m < 64; m++) begin
      for (int unsigned s = 0; s <= m; s++) begin
        for (int unsigned p = 0; p < 3; p++) begin
          sg = sacs_pkg::sign_e'(p);
          ln = (sg == sacs_pkg::SG_NP);
          rn = (sg == sacs_pkg::SG_PN);
          for (int unsigned ord = 0; ord < 2; ord++) begin
            la  = (ord != 0) ? s : m;
            ra  = (ord != 0) ? m : s;
            hit = lane_sum(r.left_a, r.right_a, ln, la, rn, ra) == r.target_a;
            if (hit && both) begin
              hit = lane_sum(r.left_b, r.right_b, ln, la, rn, ra) == r.target_b;
            end
            if (hit) begin
              res.found     = 1'b1;
              res.left_neg  = ln;
              res.right_neg = rn;
              res.left_amt  = la[4:0];
              res.right_amt = ra[4:0];
              return res;
            end
          end
        end
      end
    end
    return res;
  endfunction

  function automatic logic [63:0] rand_operand();
    logic [63:0] v;
    case ($urandom_range(0, 7))
      0, 1, 2: v = {$urandom, $urandom};
      3:       v = 64'($urandom_range(0, 31)) - 64'd16;
      4:       v = 64'd1 << $urandom_range(0, 63);
      5:       v = '0;
      6:       v = AllOnes;
      default: v = $urandom_range(0, 1) ? MaxVal : MinVal;
    endcase
    return v;
  endfunction

  function automatic int unsigned pick_shift();
    return ($urandom_range(0, 9) < 8) ? $urandom_range(0, 5) : $urandom_range(0, 19);
  endfunction

  // Builds a request from chosen shifts and signs; sign pattern 3 subtracts both
  // operands, which the search never tries, and a shift of 20 is out of reach.
  function automatic search_req_t make_match_req(input bit broken);
    search_req_t r;
    int unsigned la;
    int unsigned ra;
    int unsigned sg;
    la = pick_shift();
    ra = pick_shift();
    if (broken && $urandom_range(0, 1)) la = ShiftLimit;
    sg = $urandom_range(0, 3);
    r.left_a    = rand_operand();
    r.left_b    = rand_operand();
    r.right_a   = rand_operand();
    r.right_b   = rand_operand();
    r.two_lanes = 1'($urandom_range(0, 1));
    r.target_a  = lane_sum(r.left_a, r.right_a, sg[0], la, sg[1], ra);
    r.target_b  = lane_sum(r.left_b, r.right_b, sg[0], la, sg[1], ra);
    if (!r.two_lanes && $urandom_range(0, 1)) r.target_b = {$urandom, $urandom};
    if (broken) begin
      if (r.two_lanes && $urandom_range(0, 1)) begin
        r.target_b[$urandom_range(0, 63)] ^= 1'b1;
      end else begin
        r.target_a[$urandom_range(0, 63)] ^= 1'b1;
      end
    end
    return r;
  endfunction

  task automatic send_request(input search_req_t r, input bit known,
                              input coeff_result_t want);
    coeff_result_t exp_res;
    int unsigned   gap;
    s_axis_tdata  <= {r.target_b, r.target_a, r.right_b, r.right_a, r.left_b, r.left_a};
    s_axis_tuser  <= r.two_lanes;
    s_axis_tvalid <= 1'b1;
    do @(posedge clk_i); while (!s_axis_tready);
    exp_res = known ? want : search_coeffs(r);
    coeff_expected_q.push_back(exp_res);
    sent_count++;
    if (exp_res.found) hit_count++;
    else miss_count++;
    if (r.two_lanes) dual_count++;
    if (steady_mode) gap = 0;
    else begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4, 5: gap = 0;
        6, 7, 8:          gap = $urandom_range(1, 3);
        default:          gap = $urandom_range(10, 50);
      endcase
    end
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  task automatic drain_results();
    s_axis_tvalid <= 1'b0;
    while (coeff_expected_q.size() != 0) @(posedge clk_i);
  endtask

  task automatic check_field(input string name, input int unsigned want,
                             input int unsigned got);
    if (want != got) begin
      error_count++;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
    end
  endtask

  always @(posedge clk_i) begin
    if (steady_mode) begin
      m_axis_tready <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left    <= stall_left - 1;
      m_axis_tready <= 1'b0;
    end else begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4, 5, 6: m_axis_tready <= 1'b1;
        7, 8: begin
          m_axis_tready <= 1'b0;
          stall_left    <= $urandom_range(0, 2);
        end
        default: begin
          m_axis_tready <= 1'b0;
          stall_left    <= $urandom_range(10, 60);
        end
      endcase
    end
  end

  always @(posedge clk_i) begin : check_results
    coeff_result_t got;
    coeff_result_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got.found     = m_axis_tdata[0];
      got.left_neg  = m_axis_tdata[1];
      got.right_neg = m_axis_tdata[2];
      got.left_amt  = m_axis_tdata[7:3];
      got.right_amt = m_axis_tdata[12:8];
      result_count++;
      if (coeff_expected_q.size() == 0) begin
        error_count++;
        $display("%0t: result with no request pending, actual %h", $time, m_axis_tdata);
      end else begin
        want = coeff_expected_q.pop_front();
        check_field("found", want.found, got.found);
        check_field("left_negate", want.left_neg, got.left_neg);
        check_field("right_negate", want.right_neg, got.right_neg);
        check_field("left_amount", want.left_amt, got.left_amt);
        check_field("right_amount", want.right_amt, got.right_amt);
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("%0t: timeout with %0d results pending", $time, coeff_expected_q.size());
      $display("** shift_add_coefficient_search_core: FAILED **");
      $finish;
    end
  end

  initial begin
    table_row_t  dir_rows [20];
    search_req_t r;
    int unsigned pick;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    s_axis_tuser  <= 1'b0;
    m_axis_tready <= 1'b0;
    rst_ni        <= 1'b0;
    error_count  = 0;
    sent_count   = 0;
    hit_count    = 0;
    miss_count   = 0;
    dual_count   = 0;
    result_count = 0;
    cycle_count  = 0;
    stall_left   = 0;
    steady_mode  = 1'b0;

    dir_rows = '{
      '{'{64'd0, 64'd0, 64'd0, 64'd0, 64'd0, 64'd0, 1'b0}, 1'b1, '{1'b1, 1'b0, 1'b0, 5'd0, 5'd0}},
      '{'{64'd3, 64'd9, 64'd4, 64'd9, 64'd7, 64'd1, 1'b0}, 1'b1, '{1'b1, 1'b0, 1'b0, 5'd0, 5'd0}},
      '{'{64'd0, 64'd0, 64'd0, 64'd0, 64'd1, 64'd0, 1'b0}, 1'b1, '{1'b0, 1'b0, 1'b0, 5'd0, 5'd0}},
      '{'{64'd1, 64'd0, 64'd0, 64'd0, 64'd1 << 19, 64'd0, 1'b0}, 1'b1,
        '{1'b1, 1'b0, 1'b0, 5'd19, 5'd0}},
      '{'{64'd1, 64'd0, 64'd0, 64'd0, 64'd1 << 20, 64'd0, 1'b0}, 1'b1,
        '{1'b0, 1'b0, 1'b0, 5'd0, 5'd0}},
      '{'{64'd0, 64'd0, 64'd1, 64'd0, 64'd1 << 19, 64'd0, 1'b0}, 1'b1,
        '{1'b1, 1'b0, 1'b0, 5'd0, 5'd19}},
      '{'{64'd5, 64'd0, 64'd2, 64'd0, -64'd3, 64'd0, 1'b0}, 1'b1, '{1'b1, 1'b1, 1'b0, 5'd0, 5'd0}},
      '{'{64'd5, 64'd0, 64'd2, 64'd0, 64'd3, 64'd0, 1'b0}, 1'b1, '{1'b1, 1'b0, 1'b1, 5'd0, 5'd0}},
      '{'{64'd5, 64'd0, 64'd2, 64'd0, -64'd7, 64'd0, 1'b0}, 1'b0, '0},
      '{'{MaxVal, AllOnes, MaxVal, AllOnes, -64'd2, 64'd0, 1'b0}, 1'b1,
        '{1'b1, 1'b0, 1'b0, 5'd0, 5'd0}},
      '{'{MinVal, MinVal, MinVal, MinVal, 64'd0, 64'd0, 1'b1}, 1'b1,
        '{1'b1, 1'b0, 1'b0, 5'd0, 5'd0}},
      '{'{MinVal, 64'd0, 64'd0, 64'd0, 64'd0, 64'd0, 1'b0}, 1'b0, '0},
      '{'{64'd1, 64'd1, 64'd1, 64'd1, 64'd2, 64'd3, 1'b1}, 1'b0, '0},
      '{'{64'd1, 64'd1, 64'd1, 64'd1, 64'd2, 64'd3, 1'b0}, 1'b1, '{1'b1, 1'b0, 1'b0, 5'd0, 5'd0}},
      '{'{AllOnes, AllOnes, AllOnes, AllOnes, AllOnes, AllOnes, 1'b1}, 1'b0, '0},
      '{'{64'd1, 64'd0, 64'd1, 64'd0, 64'd0, 64'd0, 1'b0}, 1'b1, '{1'b1, 1'b1, 1'b0, 5'd0, 5'd0}},
      '{'{MaxVal, 64'd0, 64'd1, 64'd0, MinVal, 64'd0, 1'b0}, 1'b1,
        '{1'b1, 1'b0, 1'b0, 5'd0, 5'd0}},
      '{'{64'd1, 64'd1, 64'd1, 64'd1, 64'd1 << 20, 64'd1 << 20, 1'b1}, 1'b0, '0},
      '{'{64'haaaa_aaaa_aaaa_aaaa, 64'h5555_5555_5555_5555, 64'h5555_5555_5555_5555,
          64'haaaa_aaaa_aaaa_aaaa, AllOnes, AllOnes, 1'b1}, 1'b1,
        '{1'b1, 1'b0, 1'b0, 5'd0, 5'd0}},
      '{'{64'd3, 64'd5, 64'd7, 64'd1, 64'd10, 64'd11, 1'b1}, 1'b0, '0}
    };

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_rows[i]) begin
      send_request(dir_rows[i].req, dir_rows[i].known, dir_rows[i].want);
    end
    drain_results();

    for (int unsigned n = 0; n < RandomCount; n++) begin
      if (n == 200) steady_mode = 1'b1;
      if (n == 260) steady_mode = 1'b0;
      if (n % 150 == 149) drain_results();
      pick = $urandom_range(0, 99);
      if (pick < 80) r = make_match_req(1'b0);
      else if (pick < 90) r = make_match_req(1'b1);
      else begin
        r.left_a    = {$urandom, $urandom};
        r.left_b    = {$urandom, $urandom};
        r.right_a   = {$urandom, $urandom};
        r.right_b   = {$urandom, $urandom};
        r.target_a  = {$urandom, $urandom};
        r.target_b  = {$urandom, $urandom};
        r.two_lanes = 1'($urandom_range(0, 1));
      end
      send_request(r, 1'b0, '0);
    end

    drain_results();
    repeat (40) @(posedge clk_i);
    if (coeff_expected_q.size() != 0) begin
      error_count++;
      $display("%0t: %0d results never arrived", $time, coeff_expected_q.size());
    end

    $display("Sent %0d requests (%0d directed, %0d on both lanes), %0d results checked.",
             sent_count, $size(dir_rows), dual_count, result_count);
    $display("Searches ending in a match: %0d, exhausting the shift range: %0d.",
             hit_count, miss_count);
    if (error_count == 0) begin
      $display("** shift_add_coefficient_search_core: PASSED **");
    end else begin
      $display("** shift_add_coefficient_search_core: FAILED **");
    end
    $finish;
  end

endmodule
